### rtl/pvn_pkg.sv
// ----------------------------------------------------------------------------
// pvn_pkg
// Shared types and constants for the pixel vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pvn_pkg;

  localparam int MAX_COMPONENTS = 4;
  localparam int SAMPLE_BITS    = 16;
  localparam int NUM_FIELDS     = 4;

  // magnitude of a sample, square and sum of squares
  localparam int MAG_W = SAMPLE_BITS + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W = SQ_W + 2;

  // result magnitude search: one bit per stage, up to exact one (bit 15)
  localparam int QM_W  = 16;
  localparam int ITER  = 16;
  localparam int ACC_W = 72;

  localparam int CNT_W = 3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] comp_a;
    logic signed [SAMPLE_BITS-1:0] comp_b;
    logic signed [SAMPLE_BITS-1:0] comp_c;
    logic signed [SAMPLE_BITS-1:0] comp_d;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] norm_a;
    logic signed [15:0] norm_b;
    logic signed [15:0] norm_c;
    logic signed [15:0] norm_d;
  } result_t;

endpackage

`default_nettype wire

### rtl/pixel_vector_normalize.sv
// ----------------------------------------------------------------------------
// pixel_vector_normalize
// Scales a pixel vector of up to four signed components to unit length in
// signed Q1.15, with exact rounding by a bit-per-stage magnitude search.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle; the pipeline stalls while result_valid
//   is high and result_ready low; abs, square, sum, search setup, sixteen
//   search stages (one result bit each) and the output register
// reset: pipeline empty, num_components back to 4
`default_nettype none

module pixel_vector_normalize (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   pixel_valid,
  output logic                  pixel_ready,
  input  pvn_pkg::pixel_t       pixel,
  output logic                  result_valid,
  input  wire                   result_ready,
  output pvn_pkg::result_t      result,
  input  wire                   cfg_we,
  input  wire [pvn_pkg::CNT_W-1:0] cfg_data
);

  logic                        en;
  logic [pvn_pkg::CNT_W-1:0]   num_components;
  logic [pvn_pkg::CNT_W-1:0]   cnt;
  logic signed [pvn_pkg::SAMPLE_BITS-1:0] comp [pvn_pkg::NUM_FIELDS];

  // stage 1: magnitudes
  logic                        v1;
  logic [pvn_pkg::MAG_W-1:0]   a1   [pvn_pkg::NUM_FIELDS];
  logic [pvn_pkg::NUM_FIELDS-1:0] neg1, use1;
  // stage 2: squares
  logic                        v2;
  logic [pvn_pkg::SQ_W-1:0]    sq2  [pvn_pkg::NUM_FIELDS];
  logic [pvn_pkg::NUM_FIELDS-1:0] neg2, use2;
  // stage 3: sum of squares
  logic                        v3;
  logic [pvn_pkg::SQ_W-1:0]    sq3  [pvn_pkg::NUM_FIELDS];
  logic [pvn_pkg::SUM_W-1:0]   sum3;
  logic [pvn_pkg::NUM_FIELDS-1:0] neg3, use3;
  // search stages, index 0 is the setup stage
  logic                        vs   [pvn_pkg::ITER+1];
  logic signed [pvn_pkg::ACC_W-1:0] rs [pvn_pkg::ITER+1][pvn_pkg::NUM_FIELDS];
  logic signed [pvn_pkg::ACC_W-1:0] ps [pvn_pkg::ITER+1][pvn_pkg::NUM_FIELDS];
  logic [pvn_pkg::QM_W-1:0]    ms   [pvn_pkg::ITER+1][pvn_pkg::NUM_FIELDS];
  logic [pvn_pkg::SUM_W-1:0]   ss   [pvn_pkg::ITER+1];
  logic [pvn_pkg::NUM_FIELDS-1:0] negs [pvn_pkg::ITER+1];
  logic [pvn_pkg::NUM_FIELDS-1:0] uses [pvn_pkg::ITER+1];

  logic signed [pvn_pkg::ACC_W-1:0] rs_next [1:pvn_pkg::ITER][pvn_pkg::NUM_FIELDS];
  logic signed [pvn_pkg::ACC_W-1:0] ps_next [1:pvn_pkg::ITER][pvn_pkg::NUM_FIELDS];
  logic [pvn_pkg::QM_W-1:0]    ms_next [1:pvn_pkg::ITER][pvn_pkg::NUM_FIELDS];
  logic [15:0]                 norm_next [pvn_pkg::NUM_FIELDS];

  assign en          = !result_valid || result_ready;
  assign pixel_ready = en;

  assign comp[0] = pixel.comp_a;
  assign comp[1] = pixel.comp_b;
  assign comp[2] = pixel.comp_c;
  assign comp[3] = pixel.comp_d;

  assign cnt = (num_components > pvn_pkg::CNT_W'(pvn_pkg::MAX_COMPONENTS))
             ? pvn_pkg::CNT_W'(pvn_pkg::MAX_COMPONENTS) : num_components;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_components <= pvn_pkg::CNT_W'(4);
    end else if (cfg_we) begin
      num_components <= cfg_data;
    end
  end

  // one trial bit per stage: keep residual R = 2^32*a^2 - d^2*s and P = d*s,
  // with d = 2m-1; adding bit b grows d^2*s by 2^(b+2)*P + 2^(2b+2)*s
  always_comb begin
    logic [pvn_pkg::QM_W-1:0]         c;
    logic signed [pvn_pkg::ACC_W-1:0] dl;
    logic signed [pvn_pkg::ACC_W-1:0] sx;
    for (int k = 1; k <= pvn_pkg::ITER; k++) begin
      for (int i = 0; i < pvn_pkg::NUM_FIELDS; i++) begin
        c  = ms[k-1][i] | (pvn_pkg::QM_W'(1) << (pvn_pkg::ITER - k));
        sx = $signed({{(pvn_pkg::ACC_W - pvn_pkg::SUM_W){1'b0}}, ss[k-1]});
        dl = (ps[k-1][i] <<< (pvn_pkg::ITER - k + 2))
           + (sx <<< (2 * (pvn_pkg::ITER - k) + 2));
        rs_next[k][i] = rs[k-1][i];
        ps_next[k][i] = ps[k-1][i];
        ms_next[k][i] = ms[k-1][i];
        // m already at exact one: no further bit may be set
        if (!ms[k-1][i][pvn_pkg::QM_W-1] && (dl <= rs[k-1][i])) begin
          rs_next[k][i] = rs[k-1][i] - dl;
          ps_next[k][i] = ps[k-1][i] + (sx <<< (pvn_pkg::ITER - k + 1));
          ms_next[k][i] = c;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < pvn_pkg::NUM_FIELDS; i++) begin
      if (!uses[pvn_pkg::ITER][i] || (ss[pvn_pkg::ITER] == '0)) begin
        norm_next[i] = '0;
      end else if (negs[pvn_pkg::ITER][i]) begin
        norm_next[i] = 16'(pvn_pkg::QM_W'(0) - ms[pvn_pkg::ITER][i]);
      end else if (ms[pvn_pkg::ITER][i][pvn_pkg::QM_W-1]) begin
        norm_next[i] = 16'h7fff;
      end else begin
        norm_next[i] = ms[pvn_pkg::ITER][i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k <= pvn_pkg::ITER; k++) begin
        vs[k] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= pixel_valid;
      v2 <= v1;
      v3 <= v2;
      vs[0] <= v3;
      for (int k = 1; k <= pvn_pkg::ITER; k++) begin
        vs[k] <= vs[k-1];
      end
      result_valid <= vs[pvn_pkg::ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < pvn_pkg::NUM_FIELDS; i++) begin
        neg1[i] <= comp[i][pvn_pkg::SAMPLE_BITS-1];
        use1[i] <= pvn_pkg::CNT_W'(i) < cnt;
        a1[i]   <= comp[i][pvn_pkg::SAMPLE_BITS-1]
                 ? pvn_pkg::MAG_W'(0) - pvn_pkg::MAG_W'(comp[i])
                 : pvn_pkg::MAG_W'(comp[i]);
        // unused lanes drop out of the sum here
        sq2[i]  <= use1[i]
                 ? pvn_pkg::SQ_W'((2 * pvn_pkg::MAG_W)'(a1[i])
                                  * (2 * pvn_pkg::MAG_W)'(a1[i]))
                 : '0;
      end
      neg2 <= neg1;
      use2 <= use1;

      sq3  <= sq2;
      sum3 <= pvn_pkg::SUM_W'(sq2[0]) + pvn_pkg::SUM_W'(sq2[1])
            + pvn_pkg::SUM_W'(sq2[2]) + pvn_pkg::SUM_W'(sq2[3]);
      neg3 <= neg2;
      use3 <= use2;

      for (int i = 0; i < pvn_pkg::NUM_FIELDS; i++) begin
        rs[0][i] <= $signed({{(pvn_pkg::ACC_W - pvn_pkg::SQ_W - 32){1'b0}}, sq3[i], 32'b0})
                  - $signed({{(pvn_pkg::ACC_W - pvn_pkg::SUM_W){1'b0}}, sum3});
        ps[0][i] <= -$signed({{(pvn_pkg::ACC_W - pvn_pkg::SUM_W){1'b0}}, sum3});
        ms[0][i] <= '0;
      end
      ss[0]   <= sum3;
      negs[0] <= neg3;
      uses[0] <= use3;

      for (int k = 1; k <= pvn_pkg::ITER; k++) begin
        for (int i = 0; i < pvn_pkg::NUM_FIELDS; i++) begin
          rs[k][i] <= rs_next[k][i];
          ps[k][i] <= ps_next[k][i];
          ms[k][i] <= ms_next[k][i];
        end
        ss[k]   <= ss[k-1];
        negs[k] <= negs[k-1];
        uses[k] <= uses[k-1];
      end

      result.norm_a <= norm_next[0];
      result.norm_b <= norm_next[1];
      result.norm_c <= norm_next[2];
      result.norm_d <= norm_next[3];
    end
  end

endmodule

`default_nettype wire
